// ===== rtl/bsc_pkg.sv =====
// Shared types, constants and codes for the B-spline curve evaluator.
package bsc_pkg;

    // Field widths fixed by the item format.
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 7;
    localparam int KNOT_W    = 24;
    localparam int COORD_W   = 32;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Fixed-point formats: weights are signed Q1.16, spans are knot differences.
    localparam int COEF_W    = 18;
    localparam int DIFF_W    = KNOT_W + 1;
    localparam int DIV_STEPS = 19;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic signed [COEF_W-1:0] ONE_Q16 = 18'sh10000;
    localparam logic signed [COEF_W-1:0] W_MAX   = 18'sh1FFFF;
    localparam logic signed [COEF_W-1:0] W_MIN   = 18'sh20000;

    // Defaults for the top-level parameters and the configuration registers.
    localparam int DEF_MAX_POINTS   = 64;
    localparam int DEF_SPLINE_ORDER = 4;
    localparam logic [CFG_W-1:0] RST_POINTS = 7'd4;
    localparam logic [CFG_W-1:0] RST_KNOTS  = 7'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_KNOT  = 2'd0,
        CMD_POINT = 2'd1,
        CMD_EVAL  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINTS_IN_USE = 1'b0,
        REG_KNOTS_IN_USE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PT_RD,
        S_SKIP,
        S_INIT_RD,
        S_INIT_CAP,
        S_LV_RD,
        S_LV_CAP_A,
        S_LV_CAP_B,
        S_DIV_A,
        S_MUL_A,
        S_START_B,
        S_DIV_B,
        S_MUL_B,
        S_SUM,
        S_ROT,
        S_ACC_X,
        S_ACC_Y,
        S_ACC_Z,
        S_ACC_END,
        S_NEXT,
        S_FIN
    } t_state;

    // Divider request: signed numerator and denominator spans.
    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] num;
        logic signed [DIFF_W-1:0] den;
    } t_div_req;

    // Divider response: one-cycle done pulse and the clamped Q1.16 quotient.
    typedef struct packed {
        logic                     done;
        logic signed [COEF_W-1:0] q;
    } t_div_rsp;

endpackage

// ===== rtl/bsc_ifs.sv =====
// Request, result and configuration channel interfaces.
interface bsc_req_if;
    import bsc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [SLOT_W-1:0]         slot;
    logic [KNOT_W-1:0]         knot_value;
    logic [KNOT_W-1:0]         param_t;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    modport source (output valid, command, slot, knot_value, param_t, point_x, point_y,
                    point_z, input ready);
    modport sink (input valid, command, slot, knot_value, param_t, point_x, point_y,
                  point_z, output ready);
endinterface

interface bsc_res_if;
    import bsc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic signed [COORD_W-1:0] curve_z;
    logic                      saturated;
    modport source (output valid, curve_x, curve_y, curve_z, saturated, input ready);
    modport sink (input valid, curve_x, curve_y, curve_z, saturated, output ready);
endinterface

interface bsc_cfg_if;
    import bsc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bspline_curve_evaluation.sv =====
// Cubic B-spline curve evaluator: knot and point memories with a Cox-de Boor sequencer.
// Write requests leave the sequencer idle, so the block stays ready for the next request.
// An evaluate request reads and tests each point in turn; a point whose knot span does
// not cover t is skipped, and each other point runs 12 serial divisions in the recursion.
// The sums are scaled as they load the output register once it is free; the result waits there.
// Reset (synchronous, active low) restores the configuration; memories are not cleared.
module bspline_curve_evaluation #(
    parameter int MAX_POINTS   = bsc_pkg::DEF_MAX_POINTS,
    parameter int SPLINE_ORDER = bsc_pkg::DEF_SPLINE_ORDER
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsc_req_if.sink    i_req,
    bsc_res_if.source  o_res,
    bsc_cfg_if.sink    i_cfg
);
    import bsc_pkg::*;

    localparam int KNOT_DEPTH = MAX_POINTS + SPLINE_ORDER;
    localparam int KAW    = $clog2(KNOT_DEPTH);
    localparam int PAW    = $clog2(MAX_POINTS);
    localparam int CW     = ($clog2(KNOT_DEPTH + 2) > CFG_W) ? $clog2(KNOT_DEPTH + 2) : CFG_W;
    localparam int OW     = $clog2(SPLINE_ORDER + 1);
    localparam int PROD_W = COORD_W + COEF_W;
    localparam int AW     = PROD_W + $clog2(MAX_POINTS) + 1;
    localparam int TERM_W = COEF_W + 2;
    localparam logic [OW-1:0] ORD_O = OW'(SPLINE_ORDER);
    localparam logic [CW-1:0] ORD_C = CW'(SPLINE_ORDER);

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_points;
    logic [CFG_W-1:0]  r_knots;
    logic [CW-1:0]     r_i;
    logic [OW-1:0]     r_j;
    logic [OW-1:0]     r_k;
    logic [KNOT_W-1:0] r_t;
    logic [KNOT_W-1:0] r_kb1;
    logic [KNOT_W-1:0] r_kbk;
    logic [KNOT_W-1:0] r_ka;
    logic [KNOT_W-1:0] r_kb;
    logic [3*COORD_W-1:0] r_pt;
    logic signed [COEF_W-1:0] r_n [SPLINE_ORDER];
    logic signed [PROD_W-1:0] r_p;
    logic signed [TERM_W-1:0] r_term_a;
    logic signed [AW-1:0] r_acc_x;
    logic signed [AW-1:0] r_acc_y;
    logic signed [AW-1:0] r_acc_z;
    logic                 r_ovalid;
    logic signed [COORD_W-1:0] r_res_x;
    logic signed [COORD_W-1:0] r_res_y;
    logic signed [COORD_W-1:0] r_res_z;
    logic                 r_res_sat;

    logic [KNOT_W-1:0]    r_knot_mem [KNOT_DEPTH];
    logic [3*COORD_W-1:0] r_pt_mem   [MAX_POINTS];

    logic              accept;
    logic              knot_we;
    logic              pt_we;
    logic              eval_go;
    logic [CW-1:0]     slot_c;
    logic [CW-1:0]     np;
    logic [CW-1:0]     nk;
    logic [CW-1:0]     jc;
    logic [CW-1:0]     kc;
    logic [CW-1:0]     addr_a;
    logic [CW-1:0]     addr_b;
    logic [OW-1:0]     j_inc;
    logic              level_end;
    logic              last_level;
    logic              skip;
    logic              fin_load;
    logic signed [COORD_W-1:0] mul_a;
    logic signed [COEF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  p_adj;
    logic signed [TERM_W-1:0]  term_p;
    logic signed [TERM_W:0]    bsum;
    logic signed [COEF_W-1:0]  bclamp;
    logic signed [COEF_W-1:0]  flag;
    logic [COORD_W:0]          fin_x;
    logic [COORD_W:0]          fin_y;
    logic [COORD_W:0]          fin_z;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // Final scaling of a coordinate sum: divide by 2^16 toward zero, clamp to 32 bits.
    function automatic logic [COORD_W:0] fin_coord(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] adj;
        logic [AW-17:0]       q;
        logic                 hi;
        logic                 lo;
        adj = a + (a[AW-1] ? AW'(65535) : AW'(0));
        q   = adj[AW-1:16];
        hi  = !q[AW-17] && (|q[AW-17:COORD_W-1]);
        lo  = q[AW-17] && !(&q[AW-17:COORD_W-1]);
        if (hi) begin
            return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
        end else if (lo) begin
            return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
        end
        return {1'b0, q[COORD_W-1:0]};
    endfunction

    // Request and configuration handshakes.
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign accept  = i_req.valid && i_req.ready;
    assign slot_c  = CW'(i_req.slot);
    assign knot_we = accept && t_cmd'(i_req.command) == CMD_KNOT && slot_c < CW'(KNOT_DEPTH);
    assign pt_we   = accept && t_cmd'(i_req.command) == CMD_POINT && slot_c < CW'(MAX_POINTS);
    assign eval_go = accept && t_cmd'(i_req.command) == CMD_EVAL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= RST_POINTS;
            r_knots  <= RST_KNOTS;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                REG_POINTS_IN_USE: r_points <= i_cfg.data;
                REG_KNOTS_IN_USE:  r_knots  <= i_cfg.data;
            endcase
        end
    end

    // Counts limited to the store sizes.
    assign np = (CW'(r_points) > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(r_points);
    assign nk = (CW'(r_knots) > CW'(KNOT_DEPTH)) ? CW'(KNOT_DEPTH) : CW'(r_knots);

    // Knot read addresses for the two read ports.
    assign jc = CW'(r_j);
    assign kc = CW'(r_k);
    always_comb begin
        unique case (r_state)
            S_PT_RD: begin
                addr_a = r_i;
                addr_b = r_i + ORD_C;
            end
            S_INIT_RD: begin
                addr_a = r_i + jc;
                addr_b = r_i + jc + CW'(1);
            end
            S_LV_RD: begin
                addr_a = r_i + jc;
                addr_b = r_i + jc + kc - CW'(1);
            end
            S_LV_CAP_A: begin
                addr_a = r_i + jc + CW'(1);
                addr_b = r_i + jc + kc;
            end
            default: begin
                addr_a = r_i;
                addr_b = r_i;
            end
        endcase
    end

    // Knot memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (knot_we) begin
            r_knot_mem[slot_c[KAW-1:0]] <= i_req.knot_value;
        end
        r_ka <= r_knot_mem[addr_a[KAW-1:0]];
        r_kb <= r_knot_mem[addr_b[KAW-1:0]];
    end

    // Control point memory: x, y and z side by side in one word.
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt_mem[slot_c[PAW-1:0]] <= {i_req.point_x, i_req.point_y, i_req.point_z};
        end
        if (r_state == S_PT_RD) begin
            r_pt <= r_pt_mem[r_i[PAW-1:0]];
        end
    end

    // Shared divider for the recursion coefficients.
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = DIFF_W'(signed'({1'b0, r_t})) - DIFF_W'(signed'({1'b0, r_ka}));
        div_req.den   = DIFF_W'(signed'({1'b0, r_kb})) - DIFF_W'(signed'({1'b0, r_ka}));
        if (r_state == S_LV_CAP_A) begin
            div_req.start = 1'b1;
        end else if (r_state == S_START_B) begin
            div_req.start = 1'b1;
            div_req.num   = DIFF_W'(signed'({1'b0, r_kbk})) - DIFF_W'(signed'({1'b0, r_t}));
            div_req.den   = DIFF_W'(signed'({1'b0, r_kbk})) - DIFF_W'(signed'({1'b0, r_kb1}));
        end
    end

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Shared multiplier: basis terms and coordinate products.
    always_comb begin
        mul_a = COORD_W'(div_rsp.q);
        mul_b = r_n[0];
        case (r_state)
            S_MUL_B: mul_b = r_n[1];
            S_ACC_X: mul_a = signed'(r_pt[3*COORD_W-1:2*COORD_W]);
            S_ACC_Y: mul_a = signed'(r_pt[2*COORD_W-1:COORD_W]);
            S_ACC_Z: mul_a = signed'(r_pt[COORD_W-1:0]);
            default: mul_a = COORD_W'(div_rsp.q);
        endcase
    end
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Basis term: product divided by 2^16 toward zero; sum clamped to Q1.16.
    assign p_adj  = r_p + (r_p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    assign term_p = signed'(p_adj[2*COEF_W-1:16]);
    assign bsum   = (TERM_W+1)'(r_term_a) + (TERM_W+1)'(term_p);
    always_comb begin
        if (bsum > (TERM_W+1)'(W_MAX)) begin
            bclamp = W_MAX;
        end else if (bsum < (TERM_W+1)'(W_MIN)) begin
            bclamp = W_MIN;
        end else begin
            bclamp = bsum[COEF_W-1:0];
        end
    end

    // Order-one basis and the point skip tests.
    assign flag = (r_ka <= r_t && r_t < r_kb) ? ONE_Q16 : '0;
    assign skip = (r_t < r_ka) || ((r_i + ORD_C + CW'(1) <= nk) && (r_t > r_kb));

    assign j_inc      = r_j + 1'b1;
    assign level_end  = (j_inc == ORD_O);
    assign last_level = (r_k == ORD_O);
    assign fin_load   = (r_state == S_FIN) && (!r_ovalid || o_res.ready);
    assign fin_x = fin_coord(r_acc_x);
    assign fin_y = fin_coord(r_acc_y);
    assign fin_z = fin_coord(r_acc_z);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (eval_go) n_state = (np == '0) ? S_FIN : S_PT_RD;
            S_PT_RD:    n_state = S_SKIP;
            S_SKIP:     n_state = skip ? S_NEXT : S_INIT_RD;
            S_INIT_RD:  n_state = S_INIT_CAP;
            S_INIT_CAP: n_state = level_end ? S_LV_RD : S_INIT_RD;
            S_LV_RD:    n_state = S_LV_CAP_A;
            S_LV_CAP_A: n_state = S_LV_CAP_B;
            S_LV_CAP_B: n_state = S_DIV_A;
            S_DIV_A:    if (div_rsp.done) n_state = S_MUL_A;
            S_MUL_A:    n_state = S_START_B;
            S_START_B:  n_state = S_DIV_B;
            S_DIV_B:    if (div_rsp.done) n_state = S_MUL_B;
            S_MUL_B:    n_state = S_SUM;
            S_SUM, S_ROT: begin
                if (level_end) begin
                    n_state = last_level ? S_ACC_X : S_LV_RD;
                end else begin
                    n_state = (j_inc <= ORD_O - r_k) ? S_LV_RD : S_ROT;
                end
            end
            S_ACC_X:    n_state = S_ACC_Y;
            S_ACC_Y:    n_state = S_ACC_Z;
            S_ACC_Z:    n_state = S_ACC_END;
            S_ACC_END:  n_state = S_NEXT;
            S_NEXT:     n_state = (r_i + CW'(1) == np) ? S_FIN : S_PT_RD;
            S_FIN:      if (fin_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else begin
            case (r_state)
                S_IDLE: r_i <= '0;
                S_SKIP: begin
                    r_j <= '0;
                    r_k <= OW'(1);
                end
                S_INIT_CAP: begin
                    r_j <= level_end ? '0 : j_inc;
                    r_k <= level_end ? OW'(2) : r_k;
                end
                S_SUM, S_ROT: begin
                    r_j <= level_end ? '0 : j_inc;
                    r_k <= level_end ? r_k + 1'b1 : r_k;
                end
                S_NEXT: r_i <= r_i + CW'(1);
                default: r_i <= r_i;
            endcase
        end
    end

    // Basis shift line: new values enter at the top, the recursion reads the bottom two.
    always_ff @(posedge i_clk) begin
        if (r_state == S_INIT_CAP || r_state == S_SUM || r_state == S_ROT) begin
            for (int m = 0; m < SPLINE_ORDER - 1; m++) begin
                r_n[m] <= r_n[m+1];
            end
            if (r_state == S_INIT_CAP) begin
                r_n[SPLINE_ORDER-1] <= flag;
            end else if (r_state == S_SUM) begin
                r_n[SPLINE_ORDER-1] <= bclamp;
            end else begin
                r_n[SPLINE_ORDER-1] <= r_n[0];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_p <= prod;
        if (eval_go) begin
            r_t     <= i_req.param_t;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end
        if (r_state == S_LV_CAP_B) begin
            r_kb1 <= r_ka;
            r_kbk <= r_kb;
        end
        if (r_state == S_START_B) begin
            r_term_a <= term_p;
        end
        if (r_state == S_ACC_Y) begin
            r_acc_x <= r_acc_x + AW'(r_p);
        end
        if (r_state == S_ACC_Z) begin
            r_acc_y <= r_acc_y + AW'(r_p);
        end
        if (r_state == S_ACC_END) begin
            r_acc_z <= r_acc_z + AW'(r_p);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fin_load) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_res_x   <= signed'(fin_x[COORD_W-1:0]);
            r_res_y   <= signed'(fin_y[COORD_W-1:0]);
            r_res_z   <= signed'(fin_z[COORD_W-1:0]);
            r_res_sat <= fin_x[COORD_W] | fin_y[COORD_W] | fin_z[COORD_W];
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.curve_x   = r_res_x;
    assign o_res.curve_y   = r_res_y;
    assign o_res.curve_z   = r_res_z;
    assign o_res.saturated = r_res_sat;

endmodule

// ===== rtl/bsc_div.sv =====
// Radix-2 restoring divider producing a clamped signed Q1.16 ratio.
module bsc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsc_pkg::t_div_req   i_req,
    output bsc_pkg::t_div_rsp   o_rsp
);
    import bsc_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [KNOT_W-1:0]     r_rem;
    logic [KNOT_W-1:0]     r_d;
    logic [DIV_STEPS-1:0]  r_sh;
    logic [DIV_STEPS-1:0]  r_q;
    logic                  r_neg;
    logic                  r_ovf;
    logic                  r_zero;
    logic signed [COEF_W-1:0] r_res;

    logic [DIFF_W-1:0]     mag_n;
    logic [DIFF_W-1:0]     mag_d;
    logic                  ovf;
    logic [KNOT_W:0]       trial;
    logic [DIV_STEPS-1:0]  neg_q;
    logic signed [COEF_W-1:0] res;

    // Magnitudes of the operands; the quotient sign is applied at the end.
    assign mag_n = i_req.num[DIFF_W-1] ? DIFF_W'(-i_req.num) : DIFF_W'(i_req.num);
    assign mag_d = i_req.den[DIFF_W-1] ? DIFF_W'(-i_req.den) : DIFF_W'(i_req.den);
    // A ratio of 8 or more does not fit the quotient register and is clamped at once.
    assign ovf   = {3'b000, mag_n[KNOT_W-1:0]} >= {mag_d[KNOT_W-1:0], 3'b000};
    assign trial = {r_rem, r_sh[DIV_STEPS-1]};
    assign neg_q = DIV_STEPS'(0) - r_q;

    // Sign and clamp of the finished quotient.
    always_comb begin
        if (r_zero) begin
            res = '0;
        end else if (!r_neg) begin
            res = (r_ovf || r_q > DIV_STEPS'(131071)) ? W_MAX : signed'(r_q[COEF_W-1:0]);
        end else begin
            res = (r_ovf || r_q > DIV_STEPS'(131072)) ? W_MIN : signed'(neg_q[COEF_W-1:0]);
        end
    end

    // Control: one quotient bit per cycle, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (ovf || i_req.den == '0) ? '0 : DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: the upper dividend bits load directly as the first remainder.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {3'b000, mag_n[KNOT_W-1:3]};
            r_sh   <= {mag_n[2:0], 16'h0000};
            r_d    <= mag_d[KNOT_W-1:0];
            r_q    <= '0;
            r_neg  <= i_req.num[DIFF_W-1] ^ i_req.den[DIFF_W-1];
            r_ovf  <= ovf;
            r_zero <= (i_req.den == '0);
        end else if (r_busy && r_cnt != '0) begin
            r_sh <= {r_sh[DIV_STEPS-2:0], 1'b0};
            if (trial >= {1'b0, r_d}) begin
                r_rem <= KNOT_W'(trial - {1'b0, r_d});
                r_q   <= {r_q[DIV_STEPS-2:0], 1'b1};
            end else begin
                r_rem <= trial[KNOT_W-1:0];
                r_q   <= {r_q[DIV_STEPS-2:0], 1'b0};
            end
        end
        if (r_busy && r_cnt == '0) begin
            r_res <= res;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_res;

endmodule

// ===== rtl/bsc_checker.sv =====
// Port-level assertions for the B-spline evaluator, bound to the top level.
module bsc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [bsc_pkg::CMD_W-1:0]     req_command,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic signed [bsc_pkg::COORD_W-1:0] res_x,
    input logic signed [bsc_pkg::COORD_W-1:0] res_y,
    input logic signed [bsc_pkg::COORD_W-1:0] res_z,
    input logic                          res_sat
);
    import bsc_pkg::*;

    // A stalled result holds its value.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_x) && $stable(res_y)
        && $stable(res_z) && $stable(res_sat))
        else $error("result changed while stalled");

    // An accepted evaluate request keeps the block busy in the next cycle.
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready && req_command == CMD_EVAL |=> !req_ready)
        else $error("ready right after an evaluate request");

    // A write request is not followed directly by a rising result valid.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready && (req_command == CMD_KNOT || req_command == CMD_POINT)
        |=> !$rose(res_valid))
        else $error("result after a write request");

    // A saturated result carries at least one clamped coordinate.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_sat |-> res_x == 32'sh7FFFFFFF || res_x == 32'sh80000000
        || res_y == 32'sh7FFFFFFF || res_y == 32'sh80000000
        || res_z == 32'sh7FFFFFFF || res_z == 32'sh80000000)
        else $error("saturated flag without a clamped coordinate");

endmodule

bind bspline_curve_evaluation bsc_checker u_bsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .req_valid   (i_req.valid),
    .req_ready   (i_req.ready),
    .req_command (i_req.command),
    .res_valid   (o_res.valid),
    .res_ready   (o_res.ready),
    .res_x       (o_res.curve_x),
    .res_y       (o_res.curve_y),
    .res_z       (o_res.curve_z),
    .res_sat     (o_res.saturated)
);
